>>> sv/gmg_pkg.sv
// ----------------------------------------------------------------------------
// gmg_pkg: shared types and constants for the maze generate/solve block
// Cell codes, command kinds, datapath operations and status flags.
// ----------------------------------------------------------------------------
package gmg_pkg;

    localparam int KIND_W = 2;
    localparam int SEED_W = 32;
    localparam int RC_W   = 7;
    localparam int CODE_W = 2;
    localparam int PATH_W = 13;
    localparam int CFG_W  = 6;
    localparam int DIVD_W = 32;
    localparam int DVSR_W = 13;

    localparam logic [SEED_W-1:0] LFSR_TAPS = 32'h8020_0003;

    localparam logic [CODE_W-1:0] CODE_OPEN  = 2'd0;
    localparam logic [CODE_W-1:0] CODE_HWALL = 2'd1;
    localparam logic [CODE_W-1:0] CODE_VWALL = 2'd2;
    localparam logic [CODE_W-1:0] CODE_PATH  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_GEN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SOLVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_GSWEEP,
        OP_SSWEEP,
        OP_DRAW,
        OP_DIV2,
        OP_GSEED,
        OP_TOPRD,
        OP_LOAD,
        OP_NBRD,
        OP_NBCHK,
        OP_POP,
        OP_DRAWCNT,
        OP_SELDIR,
        OP_CARVE,
        OP_SINIT,
        OP_SKIP,
        OP_STEP,
        OP_SPOP,
        OP_SLOAD,
        OP_PUSH1,
        OP_PUSH2,
        OP_MRD,
        OP_MWR,
        OP_FAIL,
        OP_RRD,
        OP_RWAIT,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic div_done;
        logic sp_zero;
        logic sp_one;
        logic sp_full;
        logic cnt_zero;
        logic dir_last;
        logic cdir_end;
        logic step_ingrid;
        logic blocked;
        logic is_goal;
        logic mark_last;
    } dp_status_t;

    // order: up, right, left, down
    function automatic logic signed [1:0] step_row(input logic [1:0] d);
        case (d)
            2'd0:    step_row = -2'sd1;
            2'd3:    step_row = 2'sd1;
            default: step_row = 2'sd0;
        endcase
    endfunction

    function automatic logic signed [1:0] step_col(input logic [1:0] d);
        case (d)
            2'd1:    step_col = 2'sd1;
            2'd2:    step_col = -2'sd1;
            default: step_col = 2'sd0;
        endcase
    endfunction

    function automatic logic [SEED_W-1:0] lfsr_draw(input logic [SEED_W-1:0] w);
        logic [SEED_W-1:0] s;
        s = w >> 1;
        if (w[0])
        begin
            s = s ^ LFSR_TAPS;
        end
        lfsr_draw = s;
    endfunction

endpackage

>>> sv/gmg_ifs.sv
// ----------------------------------------------------------------------------
// gmg_ifs: handshake channels of the maze block
// Command, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface gmg_in_if import gmg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SEED_W-1:0] seed;
    logic [RC_W-1:0]   row;
    logic [RC_W-1:0]   col;
    modport source (output valid, kind, seed, row, col, input ready);
    modport sink   (input valid, kind, seed, row, col, output ready);
endinterface

interface gmg_out_if import gmg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] cell_code;
    logic [PATH_W-1:0] path_length;
    modport source (output valid, cell_code, path_length, input ready);
    modport sink   (input valid, cell_code, path_length, output ready);
endinterface

interface gmg_cfg_if import gmg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> sv/gmg_div.sv
// ----------------------------------------------------------------------------
// gmg_div: iterative restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module gmg_div import gmg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DVSR_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [DIVD_W-1:0] quot,
    output logic [DVSR_W-1:0] rem
);

    localparam int CNT_W = $clog2(DIVD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DVSR_W-1:0] rem_reg, rem_next;
    logic [DVSR_W-1:0] dvs_reg, dvs_next;
    logic [DVSR_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[DIVD_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DVSR_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DVSR_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

>>> sv/gmg_dp.sv
// ----------------------------------------------------------------------------
// gmg_dp: maze datapath
// Grid, visit and stack memories, LFSR, search registers and the divider.
// ----------------------------------------------------------------------------
module gmg_dp import gmg_pkg::*;
#(
    parameter int MAX_HALF = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic [KIND_W-1:0] in_kind,
    input  logic [SEED_W-1:0] in_seed,
    input  logic [RC_W-1:0]   in_row,
    input  logic [RC_W-1:0]   in_col,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_data,
    output logic [CODE_W-1:0] cell_code,
    output logic [PATH_W-1:0] path_length
);

    localparam int SIDE_MAX = 2 * MAX_HALF + 1;
    localparam int CELLS    = SIDE_MAX * SIDE_MAX;
    localparam int AW       = $clog2(CELLS);
    localparam int RW       = $clog2(SIDE_MAX);
    localparam int CW       = RW + 2;
    localparam int NW       = $clog2(MAX_HALF + 1);
    localparam int SPW      = $clog2(CELLS + 1);
    localparam int EW       = 2 * RW + 3;

    // memories
    logic [CODE_W-1:0] grid_mem  [CELLS];
    logic              visit_mem [CELLS];
    logic [EW-1:0]     stack_mem [CELLS];

    logic              grid_we, visit_we, stack_we;
    logic [AW-1:0]     grid_wa, grid_ra, visit_wa, visit_ra, stack_wa, stack_ra;
    logic [CODE_W-1:0] grid_wd, grid_q;
    logic              visit_wd, visit_q;
    logic [EW-1:0]     stack_wd, stack_q;

    // registers
    logic [NW-1:0]     n_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [SEED_W-1:0] seed_reg;
    logic [RC_W-1:0]   row_reg, col_reg;
    logic [SEED_W-1:0] lfsr_reg;
    logic [RW-1:0]     swr_reg, swc_reg;
    logic [RW-1:0]     cr_reg, cc_reg, nr_reg, nc_reg;
    logic [2:0]        cdir_reg;
    logic [1:0]        d_reg, dsel_reg;
    logic [2:0]        cnt_reg;
    logic [1:0]        cand_reg [4];
    logic              ing_reg;
    logic [SPW-1:0]    sp_reg;
    logic [AW-1:0]     mi_reg;
    logic [PATH_W-1:0] path_reg;
    logic [CODE_W-1:0] rd_reg;
    logic              rdin_reg;
    logic [CODE_W-1:0] out_cell_reg;
    logic [PATH_W-1:0] out_path_reg;

    // divider
    logic              div_start, div_busy, div_done;
    logic [DIVD_W-1:0] div_dividend, div_quot;
    logic [DVSR_W-1:0] div_divisor, div_rem;

    gmg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [RW-1:0] c);
        cell_addr = AW'(int'(r) * SIDE_MAX + int'(c));
    endfunction

    function automatic logic signed [CW-1:0] move(input logic [RW-1:0] p,
                                                  input logic signed [1:0] s,
                                                  input logic dbl);
        logic signed [CW-1:0] ds;
        ds = {{(CW-2){s[1]}}, s};
        if (dbl)
        begin
            ds = ds <<< 1;
        end
        move = $signed({2'b00, p}) + ds;
    endfunction

    logic [NW:0]          side;
    logic signed [CW-1:0] side_s;
    logic [SEED_W-1:0]    seed_eff, lfsr_new;
    logic [RW-1:0]        start_r, start_c;
    logic [RW-1:0]        goal_c, init_r;
    logic signed [CW-1:0] g2r, g2c, g1r, g1c, s1r, s1c;
    logic                 g2_in, s1_in;
    logic [RW-1:0]        rd_r, rd_c;
    logic                 rd_in;
    logic [CODE_W-1:0]    sweep_code;

    function automatic logic in_grid(input logic signed [CW-1:0] r,
                                     input logic signed [CW-1:0] c,
                                     input logic signed [CW-1:0] sd);
        in_grid = (r >= 0) && (r < sd) && (c >= 0) && (c < sd);
    endfunction

    always_comb
    begin
        side     = {n_reg, 1'b1};
        side_s   = $signed(CW'(side));
        seed_eff = (seed_reg == '0) ? SEED_W'(1) : seed_reg;
        lfsr_new = lfsr_draw((cmd.op == OP_DRAW) ? seed_eff : lfsr_reg);
        start_r  = RW'({div_quot[RW-2:0], 1'b1});
        start_c  = RW'({div_rem[RW-2:0], 1'b1});
        init_r   = RW'({n_reg, 1'b1} - (NW+1)'(2));
        goal_c   = init_r;
        // generate neighbor: two steps in the probe or chosen direction
        if (cmd.op == OP_CARVE)
        begin
            g2r = move(cr_reg, step_row(dsel_reg), 1'b1);
            g2c = move(cc_reg, step_col(dsel_reg), 1'b1);
        end
        else
        begin
            g2r = move(cr_reg, step_row(d_reg), 1'b1);
            g2c = move(cc_reg, step_col(d_reg), 1'b1);
        end
        g1r   = move(cr_reg, step_row(dsel_reg), 1'b0);
        g1c   = move(cc_reg, step_col(dsel_reg), 1'b0);
        g2_in = in_grid(g2r, g2c, side_s);
        s1r   = move(cr_reg, step_row(cdir_reg[1:0]), 1'b0);
        s1c   = move(cc_reg, step_col(cdir_reg[1:0]), 1'b0);
        s1_in = in_grid(s1r, s1c, side_s);
        rd_in = (32'(row_reg) < 32'(side)) && (32'(col_reg) < 32'(side));
        rd_r  = RW'(row_reg);
        rd_c  = RW'(col_reg);
        if (swr_reg[0] == 1'b0)
        begin
            sweep_code = CODE_HWALL;
        end
        else if (swc_reg[0])
        begin
            sweep_code = CODE_OPEN;
        end
        else
        begin
            sweep_code = CODE_VWALL;
        end
    end

    // memory port selection
    always_comb
    begin
        grid_we  = 1'b0;
        grid_wa  = cell_addr(swr_reg, swc_reg);
        grid_wd  = sweep_code;
        visit_we = 1'b0;
        visit_wa = cell_addr(swr_reg, swc_reg);
        visit_wd = 1'b0;
        stack_we = 1'b0;
        stack_wa = AW'(sp_reg);
        stack_wd = {RW'(g2r), RW'(g2c), 3'd0};
        grid_ra  = cell_addr(RW'(s1r), RW'(s1c));
        visit_ra = cell_addr(RW'(s1r), RW'(s1c));
        stack_ra = AW'(sp_reg - SPW'(1));
        div_start    = 1'b0;
        div_dividend = lfsr_new;
        div_divisor  = DVSR_W'(n_reg) * DVSR_W'(n_reg);
        case (cmd.op)
            OP_GSWEEP:
            begin
                // walls only inside the current grid; cells beyond keep their codes
                grid_we  = (32'(swr_reg) < 32'(side)) && (32'(swc_reg) < 32'(side));
                visit_we = 1'b1;
            end
            OP_SSWEEP:
            begin
                visit_we = 1'b1;
            end
            OP_DRAW:
            begin
                div_start = 1'b1;
            end
            OP_DIV2:
            begin
                div_start    = 1'b1;
                div_dividend = DIVD_W'(div_rem);
                div_divisor  = DVSR_W'(n_reg);
            end
            OP_GSEED:
            begin
                visit_we = 1'b1;
                visit_wa = cell_addr(start_r, start_c);
                visit_wd = 1'b1;
                stack_we = 1'b1;
                stack_wa = '0;
                stack_wd = {start_r, start_c, 3'd0};
            end
            OP_NBRD:
            begin
                visit_ra = cell_addr(RW'(g2r), RW'(g2c));
            end
            OP_DRAWCNT:
            begin
                div_start   = 1'b1;
                div_divisor = DVSR_W'(cnt_reg);
            end
            OP_CARVE:
            begin
                visit_we = 1'b1;
                visit_wa = cell_addr(RW'(g2r), RW'(g2c));
                visit_wd = 1'b1;
                grid_we  = 1'b1;
                grid_wa  = cell_addr(RW'(g1r), RW'(g1c));
                grid_wd  = CODE_OPEN;
                stack_we = 1'b1;
            end
            OP_SINIT:
            begin
                visit_we = 1'b1;
                visit_wa = cell_addr(init_r, RW'(1));
                visit_wd = 1'b1;
                stack_we = 1'b1;
                stack_wa = '0;
                stack_wd = {init_r, RW'(1), 3'd0};
            end
            OP_SPOP:
            begin
                stack_ra = AW'(sp_reg - SPW'(2));
            end
            OP_PUSH1:
            begin
                stack_we = 1'b1;
                stack_wa = AW'(sp_reg - SPW'(1));
                stack_wd = {cr_reg, cc_reg, cdir_reg};
            end
            OP_PUSH2:
            begin
                stack_we = 1'b1;
                stack_wd = {nr_reg, nc_reg, 3'd0};
                visit_we = 1'b1;
                visit_wa = cell_addr(nr_reg, nc_reg);
                visit_wd = 1'b1;
            end
            OP_MRD:
            begin
                stack_ra = mi_reg;
            end
            OP_MWR:
            begin
                grid_we = 1'b1;
                grid_wa = cell_addr(stack_q[EW-1 -: RW], stack_q[RW+2 -: RW]);
                grid_wd = CODE_PATH;
            end
            OP_RRD:
            begin
                grid_ra = cell_addr(rd_r, rd_c);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[grid_wa] <= grid_wd;
        end
        grid_q <= grid_mem[grid_ra];
    end

    always_ff @(posedge clk)
    begin
        if (visit_we)
        begin
            visit_mem[visit_wa] <= visit_wd;
        end
        visit_q <= visit_mem[visit_ra];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_wa] <= stack_wd;
        end
        stack_q <= stack_mem[stack_ra];
    end

    // half size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= NW'(20 > MAX_HALF ? MAX_HALF : 20);
        end
        else if (cfg_we)
        begin
            if (int'(cfg_data) < 2)
            begin
                n_reg <= NW'(2);
            end
            else if (int'(cfg_data) > MAX_HALF)
            begin
                n_reg <= NW'(MAX_HALF);
            end
            else
            begin
                n_reg <= NW'(cfg_data);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= SEED_W'(1);
            sp_reg   <= '0;
            path_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_DRAW, OP_DRAWCNT: lfsr_reg <= lfsr_new;
                OP_GSEED, OP_SINIT:  sp_reg <= SPW'(1);
                OP_POP, OP_SPOP:     sp_reg <= sp_reg - SPW'(1);
                OP_CARVE:            sp_reg <= sp_reg + SPW'(1);
                OP_PUSH2:
                begin
                    sp_reg   <= sp_reg + SPW'(1);
                    path_reg <= PATH_W'(sp_reg + SPW'(1));
                end
                OP_FAIL:             path_reg <= '0;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                kind_reg <= in_kind;
                seed_reg <= in_seed;
                row_reg  <= in_row;
                col_reg  <= in_col;
                swr_reg  <= '0;
                swc_reg  <= '0;
            end
            OP_GSWEEP, OP_SSWEEP:
            begin
                if (swc_reg == RW'(SIDE_MAX - 1))
                begin
                    swc_reg <= '0;
                    swr_reg <= (swr_reg == RW'(SIDE_MAX - 1)) ? '0 : swr_reg + RW'(1);
                end
                else
                begin
                    swc_reg <= swc_reg + RW'(1);
                end
            end
            OP_LOAD:
            begin
                cr_reg  <= stack_q[EW-1 -: RW];
                cc_reg  <= stack_q[RW+2 -: RW];
                d_reg   <= '0;
                cnt_reg <= '0;
            end
            OP_NBRD:
            begin
                ing_reg <= g2_in;
            end
            OP_NBCHK:
            begin
                if (ing_reg && !visit_q)
                begin
                    cand_reg[cnt_reg[1:0]] <= d_reg;
                    cnt_reg <= cnt_reg + 3'd1;
                end
                d_reg <= d_reg + 2'd1;
            end
            OP_SELDIR:
            begin
                dsel_reg <= cand_reg[div_rem[1:0]];
            end
            OP_SINIT:
            begin
                cr_reg   <= init_r;
                cc_reg   <= RW'(1);
                cdir_reg <= '0;
            end
            OP_SKIP:
            begin
                cdir_reg <= cdir_reg + 3'd1;
            end
            OP_STEP:
            begin
                cdir_reg <= cdir_reg + 3'd1;
                nr_reg   <= RW'(s1r);
                nc_reg   <= RW'(s1c);
            end
            OP_SLOAD:
            begin
                cr_reg   <= stack_q[EW-1 -: RW];
                cc_reg   <= stack_q[RW+2 -: RW];
                cdir_reg <= stack_q[2:0];
            end
            OP_PUSH2:
            begin
                cr_reg   <= nr_reg;
                cc_reg   <= nc_reg;
                cdir_reg <= '0;
                mi_reg   <= '0;
            end
            OP_MWR:
            begin
                mi_reg <= mi_reg + AW'(1);
            end
            OP_RWAIT:
            begin
                rd_reg <= rdin_reg ? grid_q : CODE_OPEN;
            end
            OP_OUT:
            begin
                out_cell_reg <= (kind_reg == KIND_READ) ? rd_reg : CODE_OPEN;
                out_path_reg <= (kind_reg == KIND_SOLVE) ? path_reg : '0;
            end
            default:
            begin
            end
        endcase
        if (cmd.op == OP_RRD)
        begin
            rdin_reg <= rd_in;
        end
    end

    always_comb
    begin
        status.sweep_last  = (swr_reg == RW'(SIDE_MAX - 1)) && (swc_reg == RW'(SIDE_MAX - 1));
        status.div_done    = div_done;
        status.sp_zero     = (sp_reg == '0);
        status.sp_one      = (sp_reg == SPW'(1));
        status.sp_full     = (sp_reg == SPW'(CELLS));
        status.cnt_zero    = (cnt_reg == '0);
        status.dir_last    = (d_reg == 2'd3);
        status.cdir_end    = cdir_reg[2];
        status.step_ingrid = s1_in;
        status.blocked     = (grid_q != CODE_OPEN) || visit_q;
        status.is_goal     = (nr_reg == RW'(1)) && (nc_reg == goal_c);
        status.mark_last   = ((SPW'(mi_reg) + SPW'(1)) == sp_reg);
    end

    assign cell_code   = out_cell_reg;
    assign path_length = out_path_reg;

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(CELLS))
        else $error("stack pointer beyond stack depth");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_carve_cand: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_CARVE) |-> (cnt_reg != '0))
        else $error("carve without an unvisited neighbor");

    a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_MRD) |-> (SPW'(mi_reg) < sp_reg))
        else $error("path mark beyond stack top");

endmodule

>>> sv/gmg_ctrl.sv
// ----------------------------------------------------------------------------
// gmg_ctrl: maze command sequencer
// Steps the datapath through sweep, carve, search, mark and read phases.
// ----------------------------------------------------------------------------
module gmg_ctrl import gmg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [KIND_W-1:0] in_kind,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  dp_status_t        status,
    output dp_cmd_t           cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_G_SWEEP,
        ST_G_DRAW,
        ST_G_W1,
        ST_G_W2,
        ST_G_TOP,
        ST_G_LOAD,
        ST_G_NBRD,
        ST_G_NBCHK,
        ST_G_CHOOSE,
        ST_G_CWAIT,
        ST_G_CARVE,
        ST_S_SWEEP,
        ST_S_INIT,
        ST_S_STEP,
        ST_S_CHK,
        ST_S_PUSH1,
        ST_S_PUSH2,
        ST_S_SLOAD,
        ST_S_MRD,
        ST_S_MWR,
        ST_R_RD,
        ST_R_WAIT,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LATCH;
                    case (in_kind)
                        KIND_GEN:   state_next = ST_G_SWEEP;
                        KIND_SOLVE: state_next = ST_S_SWEEP;
                        KIND_READ:  state_next = ST_R_RD;
                        default:    state_next = ST_FIN;
                    endcase
                end
            end
            ST_G_SWEEP:
            begin
                cmd.op = OP_GSWEEP;
                if (status.sweep_last)
                begin
                    state_next = ST_G_DRAW;
                end
            end
            ST_G_DRAW:
            begin
                cmd.op     = OP_DRAW;
                state_next = ST_G_W1;
            end
            ST_G_W1:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_DIV2;
                    state_next = ST_G_W2;
                end
            end
            ST_G_W2:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_GSEED;
                    state_next = ST_G_TOP;
                end
            end
            ST_G_TOP:
            begin
                if (status.sp_zero)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.op     = OP_TOPRD;
                    state_next = ST_G_LOAD;
                end
            end
            ST_G_LOAD:
            begin
                cmd.op     = OP_LOAD;
                state_next = ST_G_NBRD;
            end
            ST_G_NBRD:
            begin
                cmd.op     = OP_NBRD;
                state_next = ST_G_NBCHK;
            end
            ST_G_NBCHK:
            begin
                cmd.op     = OP_NBCHK;
                state_next = status.dir_last ? ST_G_CHOOSE : ST_G_NBRD;
            end
            ST_G_CHOOSE:
            begin
                if (status.cnt_zero)
                begin
                    cmd.op     = OP_POP;
                    state_next = ST_G_TOP;
                end
                else
                begin
                    cmd.op     = OP_DRAWCNT;
                    state_next = ST_G_CWAIT;
                end
            end
            ST_G_CWAIT:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_SELDIR;
                    state_next = ST_G_CARVE;
                end
            end
            ST_G_CARVE:
            begin
                cmd.op     = OP_CARVE;
                state_next = ST_G_TOP;
            end
            ST_S_SWEEP:
            begin
                cmd.op = OP_SSWEEP;
                if (status.sweep_last)
                begin
                    state_next = ST_S_INIT;
                end
            end
            ST_S_INIT:
            begin
                cmd.op     = OP_SINIT;
                state_next = ST_S_STEP;
            end
            ST_S_STEP:
            begin
                if (status.sp_full)
                begin
                    cmd.op     = OP_FAIL;
                    state_next = ST_FIN;
                end
                else if (status.cdir_end)
                begin
                    if (status.sp_one)
                    begin
                        cmd.op     = OP_FAIL;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        cmd.op     = OP_SPOP;
                        state_next = ST_S_SLOAD;
                    end
                end
                else if (!status.step_ingrid)
                begin
                    cmd.op = OP_SKIP;
                end
                else
                begin
                    cmd.op     = OP_STEP;
                    state_next = ST_S_CHK;
                end
            end
            ST_S_CHK:
            begin
                state_next = status.blocked ? ST_S_STEP : ST_S_PUSH1;
            end
            ST_S_PUSH1:
            begin
                cmd.op     = OP_PUSH1;
                state_next = ST_S_PUSH2;
            end
            ST_S_PUSH2:
            begin
                cmd.op     = OP_PUSH2;
                state_next = status.is_goal ? ST_S_MRD : ST_S_STEP;
            end
            ST_S_SLOAD:
            begin
                cmd.op     = OP_SLOAD;
                state_next = ST_S_STEP;
            end
            ST_S_MRD:
            begin
                cmd.op     = OP_MRD;
                state_next = ST_S_MWR;
            end
            ST_S_MWR:
            begin
                cmd.op     = OP_MWR;
                state_next = status.mark_last ? ST_FIN : ST_S_MRD;
            end
            ST_R_RD:
            begin
                cmd.op     = OP_RRD;
                state_next = ST_R_WAIT;
            end
            ST_R_WAIT:
            begin
                cmd.op     = OP_RWAIT;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // result register free or emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |=> out_valid)
        else $error("result loaded but not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start a command");

endmodule

>>> sv/grid_maze_generate_and_solve_top.sv
// ----------------------------------------------------------------------------
// grid_maze_generate_and_solve_top: maze generator and solver
// Carves a random maze on a (2N+1)-square grid, solves it and reads cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one command beat (kind, seed, row, col); kind 0 generate,
//            1 solve, 2 read one cell, 3 no-op.
//   out_ch : one result beat per command (cell_code, path_length).
//   cfg    : half_size write, always ready; write only while idle.
// One command is worked on at a time; in_ch is ready only when idle, and
// a new command is taken while the previous result still waits on out_ch.
// Phases, with S = 2*MAX_HALF+1 (65 by default):
//   generate: a sweep of all S*S cells, a random start cell drawn with
//             the divider, then per maze cell neighbor probes, a random
//             draw to carve into it and a pop to back out of it.
//   solve:    a sweep of all S*S cells, the search steps, then a pass
//             that marks each path cell.
//   read:     one grid read of the given row and col; no-op: result only.
// Visit marks are cleared by the sweep of each generate and solve, so reset
// needs no clearing pass. A stalled out_ch holds the finished command's
// result and the sequencer waits before loading the next one.
// ----------------------------------------------------------------------------
module grid_maze_generate_and_solve_top import gmg_pkg::*;
#(
    parameter int MAX_HALF = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    gmg_in_if.sink       in_ch,
    gmg_out_if.source    out_ch,
    gmg_cfg_if.sink      cfg
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    gmg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_kind   (in_ch.kind),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    gmg_dp #(
        .MAX_HALF (MAX_HALF)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_kind     (in_ch.kind),
        .in_seed     (in_ch.seed),
        .in_row      (in_ch.row),
        .in_col      (in_ch.col),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg.data),
        .cell_code   (out_ch.cell_code),
        .path_length (out_ch.path_length)
    );

endmodule
